@@ hdl/lru_set_assoc_tag_lookup_assert.svh @@
// ----------------------------------------------------------------------------
// lru set-associative tag lookup assertion macros
// shorthand for clocked assertions, held off during reset
// ----------------------------------------------------------------------------
`ifndef LRU_SET_ASSOC_TAG_LOOKUP_ASSERT_SVH
`define LRU_SET_ASSOC_TAG_LOOKUP_ASSERT_SVH

// property must hold at every clock edge out of reset
`define LSA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen out of reset
`define LSA_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ hdl/lsa_pkg.sv @@
// ----------------------------------------------------------------------------
// lsa_pkg
// shared sizes, types and outcome codes of the lru tag lookup
// ----------------------------------------------------------------------------
package lsa_pkg;

  // geometry of the tag store
  localparam int SETS     = 64;
  localparam int WAYS     = 8;
  localparam int TAG_BITS = 20;

  localparam int SET_BITS     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_IDX_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WAY_CNT_BITS = $clog2(WAYS + 1);

  // ways-in-use register
  localparam int              CFG_BITS      = 4;
  localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd8;

  // outcome codes
  localparam int OUTCOME_BITS = 2;
  localparam logic [OUTCOME_BITS-1:0] OUT_HIT      = 2'd0;
  localparam logic [OUTCOME_BITS-1:0] OUT_COLD     = 2'd1;
  localparam logic [OUTCOME_BITS-1:0] OUT_CONFLICT = 2'd2;

  // stream widths, padded to whole bytes
  localparam int IN_DATA_BITS  = 32;
  localparam int OUT_DATA_BITS = 8;

  // one set row of tags, position 0 most recent
  typedef logic [WAYS-1:0][TAG_BITS-1:0] tag_row_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch item and start row read
    logic commit;   // write row back and load outcome
  } lsa_cmd_t;

endpackage

@@ hdl/lru_set_assoc_tag_lookup.sv @@
// ----------------------------------------------------------------------------
// lru_set_assoc_tag_lookup
// tag store of a set-associative cache with lru replacement per set
// ----------------------------------------------------------------------------
// access items enter on the s_axis channel (set index and tag), one outcome
// item per access leaves on m_axis: hit, cold miss or conflict miss.
// ways_in_use is written on the cfg channel; the user must write it only while
// no access is pending, as the block itself does not enforce it. the set row
// is read from the tag memory on the accepting edge, then compared, shifted
// and written back once the output slot is free; no new item is taken before that
// write-back. the outcome is visible on m_axis the cycle after write-back.
// reset marks every set empty through one flag per set and sets ways_in_use
// to 8; the block accepts items in the first cycle after reset.
// the outcome sits in an output register: with m_axis stalled the block still
// accepts one more item and holds it, row already read, until the slot frees.
// ----------------------------------------------------------------------------
module lru_set_assoc_tag_lookup (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // [5:0] set_index, [25:6] tag, rest zero
  input  logic [lsa_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [1:0] outcome, rest zero
  output logic [lsa_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic [lsa_pkg::CFG_BITS-1:0]         cfg_data_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o
);
  import lsa_pkg::*;

  lsa_cmd_t                 cmd;
  logic [CFG_BITS-1:0]      ways_in_use_q;
  logic [OUTCOME_BITS-1:0]  outcome;

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ways_in_use_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      ways_in_use_q <= cfg_data_i;
    end
  end

  lsa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd)
  );

  lsa_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .set_index_i   (s_axis_tdata[SET_BITS-1:0]),
    .tag_i         (s_axis_tdata[SET_BITS +: TAG_BITS]),
    .ways_in_use_i (ways_in_use_q),
    .outcome_o     (outcome)
  );

  assign m_axis_tdata = OUT_DATA_BITS'(outcome);

  // checks
  `include "lru_set_assoc_tag_lookup_assert.svh"

  `LSA_ASSERT(a_one_in_flight, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "second item accepted during lookup")
  `LSA_ASSERT_NEVER(a_cmd_overlap, (cmd.capture && cmd.commit), "capture and commit in the same cycle")
  `LSA_ASSERT(a_outcome_code, m_axis_tvalid |-> (outcome == OUT_HIT || outcome == OUT_COLD || outcome == OUT_CONFLICT), "reserved outcome code")

endmodule

@@ hdl/lsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// lsa_ctrl
// sequencer for lookup: accept item, then compare and write back
// ----------------------------------------------------------------------------
module lsa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  output logic            m_valid_o,
  input  logic            m_ready_i,
  output lsa_pkg::lsa_cmd_t cmd_o
);
  import lsa_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  // output slot can take a result this cycle
  assign slot_free = !out_valid_q || m_ready_i;

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result slot occupancy
  assign out_valid_d = (out_valid_q && !m_ready_i) || cmd_o.commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = out_valid_q;

endmodule

@@ hdl/lsa_datapath.sv @@
// ----------------------------------------------------------------------------
// lsa_datapath
// tag row memory, valid bits, parallel compare and recency shift
// ----------------------------------------------------------------------------
module lsa_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lsa_pkg::lsa_cmd_t                   cmd_i,
  input  logic [lsa_pkg::SET_BITS-1:0]        set_index_i,
  input  logic [lsa_pkg::TAG_BITS-1:0]        tag_i,
  input  logic [lsa_pkg::CFG_BITS-1:0]        ways_in_use_i,
  output logic [lsa_pkg::OUTCOME_BITS-1:0]    outcome_o
);
  import lsa_pkg::*;

  tag_row_t                  mem_q [SETS];
  logic [WAYS-1:0]           valid_mem_q [SETS];
  logic [SETS-1:0]           set_used_q;
  logic [SET_BITS-1:0]       set_q;
  logic [TAG_BITS-1:0]       tag_q;
  tag_row_t                  rd_row_q;
  logic [WAYS-1:0]           rd_valid_q;
  logic                      rd_used_q;
  logic [OUTCOME_BITS-1:0]   outcome_q, outcome_d;

  logic [WAYS-1:0]           valid_row;
  logic [WAY_CNT_BITS-1:0]   act_ways;
  logic [WAY_IDX_BITS-1:0]   shift_last;
  tag_row_t                  new_row;
  logic [WAYS-1:0]           new_valid;

  // item latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      set_q <= set_index_i;
      tag_q <= tag_i;
    end
  end

  // tag row and valid row memories, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd_row_q   <= mem_q[set_index_i];
      rd_valid_q <= valid_mem_q[set_index_i];
    end
    if (cmd_i.commit) begin
      mem_q[set_q]       <= new_row;
      valid_mem_q[set_q] <= new_valid;
    end
  end

  // one flag per set, cleared at reset, set once the set row is written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_used_q <= '0;
      rd_used_q  <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        rd_used_q <= set_used_q[set_index_i];
      end
      if (cmd_i.commit) begin
        set_used_q[set_q] <= 1'b1;
      end
    end
  end

  // a set never written reads as all lines invalid
  assign valid_row = rd_used_q ? rd_valid_q : '0;

  // clamp ways in use to 1..WAYS
  always_comb begin
    if (ways_in_use_i == '0) begin
      act_ways = WAY_CNT_BITS'(1);
    end else if (int'(ways_in_use_i) > WAYS) begin
      act_ways = WAY_CNT_BITS'(WAYS);
    end else begin
      act_ways = WAY_CNT_BITS'(ways_in_use_i);
    end
  end

  // first active position that matches or is empty decides the outcome
  always_comb begin
    logic                    found;
    logic                    hit;
    logic [WAY_IDX_BITS-1:0] pos;
    found = 1'b0;
    hit   = 1'b0;
    pos   = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (!found && (i < int'(act_ways))) begin
        if (!valid_row[i]) begin
          found = 1'b1;
          pos   = WAY_IDX_BITS'(i);
        end else if (rd_row_q[i] == tag_q) begin
          found = 1'b1;
          hit   = 1'b1;
          pos   = WAY_IDX_BITS'(i);
        end
      end
    end
    if (hit) begin
      outcome_d  = OUT_HIT;
      shift_last = pos;
    end else begin
      outcome_d  = found ? OUT_COLD : OUT_CONFLICT;
      shift_last = WAY_IDX_BITS'(act_ways - WAY_CNT_BITS'(1));
    end
  end

  // shift lines back up to the chosen position, new tag at the front
  always_comb begin
    for (int j = 0; j < WAYS; j++) begin
      if (j == 0) begin
        new_row[j]   = tag_q;
        new_valid[j] = 1'b1;
      end else if (j <= int'(shift_last)) begin
        new_row[j]   = rd_row_q[j-1];
        new_valid[j] = valid_row[j-1];
      end else begin
        new_row[j]   = rd_row_q[j];
        new_valid[j] = valid_row[j];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      outcome_q <= outcome_d;
    end
  end

  assign outcome_o = outcome_q;

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the lru set-associative tag lookup
// ----------------------------------------------------------------------------
// access items (set index, tag) go in on s_axis and every item is run through
// a local copy of the tag store and recency order to predict its outcome.
// outcome items on m_axis are checked in order against those predictions (or a
// directed row's own outcome). a short directed table comes first, then random
// phases with their own ways_in_use and one of four gap/stall patterns in turn.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lsa_pkg::*;

  localparam int  PHASES           = 10;
  localparam int  PHASE_ITEMS      = 108;
  localparam int  LONG_HOLD_CYCLES = 300;
  localparam int  DRAIN_CYCLES     = 8;
  localparam int  MAX_PRINTS       = 60;
  localparam int  DIR_ROWS         = 23;
  localparam real TIMEOUT_NS       = 1000000.0;

  // idling patterns of the two sides
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // one row of the directed table
  typedef struct packed {
    logic [SET_BITS-1:0]     set_idx;
    logic [TAG_BITS-1:0]     tag;
    logic                    known;
    logic [OUTCOME_BITS-1:0] outcome;
  } access_row_t;

  // one outcome still to arrive
  typedef struct packed {
    logic [SET_BITS-1:0]     set_idx;
    logic [TAG_BITS-1:0]     tag;
    logic [OUTCOME_BITS-1:0] outcome;
  } pending_outcome_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic [IN_DATA_BITS-1:0]       s_axis_tdata  = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [OUT_DATA_BITS-1:0]      m_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [CFG_BITS-1:0]           cfg_data_i    = '0;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;

  // side information travelling with the item on offer
  logic                          row_known     = 1'b0;
  logic [OUTCOME_BITS-1:0]       row_outcome   = OUT_HIT;

  idle_mode_t                    idle_mode      = IDLE_NONE;
  logic                          long_hold_req  = 1'b0;
  logic                          long_hold_done = 1'b0;
  int                            hold_left      = 0;

  int                            accesses_sent = 0;
  int                            outcomes_seen = 0;
  int                            error_count   = 0;

  // local copy of the tag store, recency order and ways setting
  logic [TAG_BITS-1:0]           tag_copy   [SETS][WAYS] = '{default: '0};
  logic [WAYS-1:0]               valid_copy [SETS]       = '{default: '0};
  logic [CFG_BITS-1:0]           ways_copy  = CFG_RESET;

  pending_outcome_t              pending_outcomes [$];

  // directed table, all at the reset setting of eight ways
  access_row_t directed_rows [DIR_ROWS] = '{
    '{6'd0,  20'h00000, 1'b1, OUT_COLD},      // empty set
    '{6'd0,  20'h00000, 1'b1, OUT_HIT},       // same tag again
    '{6'd63, 20'hFFFFF, 1'b1, OUT_COLD},      // top set, all-ones tag
    '{6'd63, 20'hFFFFF, 1'b1, OUT_HIT},
    '{6'd63, 20'h00000, 1'b1, OUT_COLD},      // second line of the set
    '{6'd63, 20'hFFFFF, 1'b1, OUT_HIT},       // hit behind the front
    '{6'd63, 20'h00000, 1'b1, OUT_HIT},
    '{6'd21, 20'h00001, 1'b1, OUT_COLD},      // fill one set completely
    '{6'd21, 20'h00002, 1'b1, OUT_COLD},
    '{6'd21, 20'h00003, 1'b1, OUT_COLD},
    '{6'd21, 20'h00004, 1'b1, OUT_COLD},
    '{6'd21, 20'h00005, 1'b1, OUT_COLD},
    '{6'd21, 20'h00006, 1'b1, OUT_COLD},
    '{6'd21, 20'h00007, 1'b1, OUT_COLD},
    '{6'd21, 20'h00008, 1'b1, OUT_COLD},
    '{6'd21, 20'h00009, 1'b1, OUT_CONFLICT},  // full set, oldest goes
    '{6'd21, 20'h00001, 1'b0, OUT_HIT},       // evicted line comes back
    '{6'd21, 20'h00002, 1'b0, OUT_HIT},
    '{6'd21, 20'h00009, 1'b0, OUT_HIT},
    '{6'd21, 20'h00003, 1'b0, OUT_HIT},       // another evicted line comes back
    '{6'd0,  20'hAAAAA, 1'b1, OUT_COLD},
    '{6'd42, 20'h55555, 1'b1, OUT_COLD},
    '{6'd0,  20'h00000, 1'b0, OUT_HIT}
  };

  // ways_in_use per random phase, extremes and saturation among them
  logic [CFG_BITS-1:0] phase_ways [PHASES] = '{
    4'd2, 4'd8, 4'd0, 4'd1, 4'd15, 4'd3, 4'd9, 4'd5, 4'd7, 4'd4
  };

  lru_set_assoc_tag_lookup dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),   // [5:0] set_index, [25:6] tag, rest zero
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [1:0] outcome, rest zero
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_data_i    (cfg_data_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o)
  );

  // clock, 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // look up one access in the local copy, update recency, give the outcome
  function automatic logic [OUTCOME_BITS-1:0] lookup_and_update(
    input logic [SET_BITS-1:0] set_idx,
    input logic [TAG_BITS-1:0] tag
  );
    int                      active;
    int                      last;
    logic                    found;
    logic [OUTCOME_BITS-1:0] outcome;
    active  = (ways_copy == 0) ? 1 : ((ways_copy > WAYS) ? WAYS : int'(ways_copy));
    last    = active - 1;
    found   = 1'b0;
    outcome = OUT_CONFLICT;
    for (int i = 0; i < active; i++) begin
      if (!found) begin
        if (valid_copy[set_idx][i] && tag_copy[set_idx][i] == tag) begin
          outcome = OUT_HIT;
          last    = i;
          found   = 1'b1;
        end else if (!valid_copy[set_idx][i]) begin
          outcome = OUT_COLD;
          found   = 1'b1;
        end
      end
    end
    // lines in front of the chosen position move back by one
    for (int j = last; j > 0; j--) begin
      tag_copy[set_idx][j]   = tag_copy[set_idx][j-1];
      valid_copy[set_idx][j] = valid_copy[set_idx][j-1];
    end
    tag_copy[set_idx][0]   = tag;
    valid_copy[set_idx][0] = 1'b1;
    return outcome;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("%0t ns: %s", $realtime, msg);
    end
  endtask

  function automatic logic sender_idles();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 56;
      IDLE_BOTH:   return $urandom_range(0, 99) < 19;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stalls();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(0, 99) < 56;
      IDLE_BOTH:     return $urandom_range(0, 99) < 19;
      default:       return 1'b0;
    endcase
  endfunction

  // offer one access item and wait until it is taken
  task automatic send_access(
    input logic [SET_BITS-1:0]     set_idx,
    input logic [TAG_BITS-1:0]     tag,
    input logic                    known,
    input logic [OUTCOME_BITS-1:0] outcome
  );
    while (sender_idles()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= {{(IN_DATA_BITS-SET_BITS-TAG_BITS){1'b0}}, tag, set_idx};
    s_axis_tvalid <= 1'b1;
    row_known     <= known;
    row_outcome   <= outcome;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    accesses_sent++;
  endtask

  // write ways_in_use once every outstanding outcome has come back
  task automatic set_ways_in_use(input logic [CFG_BITS-1:0] ways);
    s_axis_tvalid <= 1'b0;
    while (outcomes_seen != accesses_sent) @(posedge clk_i);
    cfg_data_i  <= ways;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      hold_left      <= LONG_HOLD_CYCLES;
      long_hold_done <= 1'b1;
      m_axis_tready  <= 1'b0;
    end else begin
      m_axis_tready <= !receiver_stalls();
    end
  end

  // monitor: predict on accepted accesses and ways writes, check outcomes
  always @(posedge clk_i) begin
    pending_outcome_t        entry;
    logic [OUTCOME_BITS-1:0] predicted;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        ways_copy = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        entry.set_idx = s_axis_tdata[SET_BITS-1:0];
        entry.tag     = s_axis_tdata[SET_BITS +: TAG_BITS];
        predicted     = lookup_and_update(entry.set_idx, entry.tag);
        entry.outcome = row_known ? row_outcome : predicted;
        pending_outcomes.push_back(entry);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch($sformatf("outcome item %0d with none expected",
                                    m_axis_tdata[OUTCOME_BITS-1:0]));
        end else begin
          entry = pending_outcomes.pop_front();
          outcomes_seen++;
          if (m_axis_tdata[OUTCOME_BITS-1:0] !== entry.outcome) begin
            report_mismatch($sformatf("set %0d tag %h: outcome %0d, expected %0d",
                                      entry.set_idx, entry.tag,
                                      m_axis_tdata[OUTCOME_BITS-1:0], entry.outcome));
          end
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    logic [SET_BITS-1:0] hot_sets [4];
    logic [TAG_BITS-1:0] tag_pool [12];
    int                  pool_size;
    logic [SET_BITS-1:0] set_idx;
    logic [TAG_BITS-1:0] tag;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table at the reset setting
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_access(directed_rows[r].set_idx, directed_rows[r].tag,
                  directed_rows[r].known, directed_rows[r].outcome);
    end

    // random phases: mostly reuse of a few sets and tags, some noise
    for (int p = 0; p < PHASES; p++) begin
      set_ways_in_use(phase_ways[p]);
      idle_mode <= idle_mode_t'(p % 4);
      if (p == 0) long_hold_req <= 1'b1;
      for (int k = 0; k < 4; k++) hot_sets[k] = SET_BITS'($urandom_range(0, SETS - 1));
      for (int k = 0; k < 12; k++) tag_pool[k] = TAG_BITS'($urandom);
      pool_size = $urandom_range(2, 12);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 80) begin
          set_idx = hot_sets[$urandom_range(0, 3)];
          tag     = tag_pool[$urandom_range(0, pool_size - 1)];
        end else begin
          set_idx = SET_BITS'($urandom_range(0, SETS - 1));
          tag     = TAG_BITS'($urandom);
        end
        send_access(set_idx, tag, 1'b0, OUT_HIT);
      end
    end

    // drain and finish
    s_axis_tvalid <= 1'b0;
    while (outcomes_seen != accesses_sent) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS lru_set_assoc_tag_lookup");
    end else begin
      $display("FAIL lru_set_assoc_tag_lookup");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #(TIMEOUT_NS * 1ns);
    $display("FAIL lru_set_assoc_tag_lookup");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/lsa_pkg.sv
hdl/lsa_ctrl.sv
hdl/lsa_datapath.sv
hdl/lru_set_assoc_tag_lookup.sv
verif/tb_top.sv
